### hdl/wes_pkg.sv
// ----------------------------------------------------------------------------
// wes_pkg
// Shared sizes, state encoding and the grey-level mapping for the wave
// equation stencil step unit.
// ----------------------------------------------------------------------------
package wes_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int LEN_W      = IDX_W + 1;
    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int PIXEL_W    = 8;

    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(3);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_POINTS);

    localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(655);

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_STEP = 1'b1
    } req_type_t;

    typedef enum logic {
        CFG_POINTS = 1'b0,
        CFG_COEFF  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_DRAIN
    } state_t;

    // pixel = trunc((v + 16384) * 127 / 16384), clamped to 0..255
    function automatic logic [PIXEL_W-1:0] grey_level(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W:0] off;
        logic [23:0]              scaled;
        logic [9:0]               q;
        off    = (SAMPLE_W+1)'(v) + (SAMPLE_W+1)'(16384);
        scaled = {8'd0, off[SAMPLE_W-1:0]} * 24'd127;
        q      = scaled[23:14];
        if (off < 0) begin
            return '0;
        end
        else if (q > 10'd255) begin
            return '1;
        end
        else begin
            return q[PIXEL_W-1:0];
        end
    endfunction

endpackage

### hdl/wave_equation_stencil_step_unit.sv
// ----------------------------------------------------------------------------
// wave_equation_stencil_step_unit
// Load request: 1 result, strobed after the unit passes through the load
//   state; the next request may be accepted once the unit is back in idle.
// Step request over n points: points are read from the row RAMs in order,
//   pass stages B, C and D and are strobed in order; busy holds until drained.
// Reset clears control, load position and configuration (64 points,
//   coefficient 655); row RAMs hold garbage until loaded. The receiver
//   cannot stall.
// ----------------------------------------------------------------------------
module wave_equation_stencil_step_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic signed [wes_pkg::SAMPLE_W-1:0] sample,
    output logic                               strobe,
    output logic [wes_pkg::PIXEL_W-1:0]        pixel,
    output logic [wes_pkg::IDX_W-1:0]          point_index,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [15:0]                        cfg_data
);

    import wes_pkg::*;

    // configuration
    logic [LEN_W-1:0]   points_reg;
    logic [COEFF_W-1:0] coeff_reg;
    logic [LEN_W-1:0]   row_len;

    // control
    state_t             state_reg;
    state_t             state_next;
    logic [LEN_W-1:0]   rd_cnt_reg;
    logic [LEN_W-1:0]   rd_cnt_next;
    logic [LEN_W-1:0]   load_pos_reg;
    logic [LEN_W-1:0]   load_pos_next;
    logic               accept;
    logic               issue;
    logic               load_wr;

    // load request
    logic [LEN_W-1:0]          ld_pos;
    logic [LEN_W-1:0]          ld_pos_inc;
    logic [IDX_W-1:0]          ld_idx_reg;
    logic signed [SAMPLE_W-1:0] ld_val_reg;

    // row memories
    logic                      ram_wr_en;
    logic [IDX_W-1:0]          ram_wr_addr;
    logic [SAMPLE_W-1:0]       cur_wr_data;
    logic [SAMPLE_W-1:0]       prev_wr_data;
    logic [SAMPLE_W-1:0]       cur_rd_data;
    logic [SAMPLE_W-1:0]       prev_rd_data;

    // stage B: read data back, stencil window
    logic                      b_vld_reg;
    logic [LEN_W-1:0]          b_idx_reg;
    logic signed [SAMPLE_W-1:0] win_l_reg;
    logic signed [SAMPLE_W-1:0] win_m_reg;
    logic signed [SAMPLE_W-1:0] prev_d_reg;
    logic                      b_proc;
    logic [LEN_W-1:0]          b_point;
    logic signed [17:0]        lap;

    // stage C: product
    logic                      c_vld_reg;
    logic [IDX_W-1:0]          c_idx_reg;
    logic signed [34:0]        c_prod_reg;
    logic signed [SAMPLE_W-1:0] c_mid_reg;
    logic signed [SAMPLE_W-1:0] c_prev_reg;
    logic                      c_edge_reg;
    logic                      c_last_reg;
    logic signed [35:0]        c_rnd;
    logic signed [19:0]        c_term;
    logic signed [21:0]        c_sum;
    logic signed [SAMPLE_W-1:0] c_next;

    // stage D: write back and emit
    logic                      d_vld_reg;
    logic [IDX_W-1:0]          d_idx_reg;
    logic signed [SAMPLE_W-1:0] d_next_reg;
    logic signed [SAMPLE_W-1:0] d_mid_reg;
    logic                      d_last_reg;

    // output
    logic                      strobe_reg;
    logic [PIXEL_W-1:0]        pixel_reg;
    logic [IDX_W-1:0]          index_reg;
    logic                      last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg <= MAX_LEN;
            coeff_reg  <= COEFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_POINTS: points_reg <= cfg_data[LEN_W-1:0];
                CFG_COEFF:  coeff_reg  <= cfg_data[COEFF_W-1:0];
                default:    points_reg <= points_reg;
            endcase
        end
    end

    assign row_len = (points_reg < MIN_LEN) ? MIN_LEN :
                     ((points_reg > MAX_LEN) ? MAX_LEN : points_reg);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_type_t'(req_type) == REQ_STEP) ? ST_STEP : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            ST_STEP:
            begin
                if (rd_cnt_reg == row_len)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!b_vld_reg && !c_vld_reg && !d_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy    = 1'b1;
        issue   = 1'b0;
        load_wr = 1'b0;
        case (state_reg)
            ST_IDLE:  busy    = 1'b0;
            ST_LOAD:  load_wr = 1'b1;
            ST_STEP:  issue   = 1'b1;
            ST_DRAIN: busy    = 1'b1;
            default:  busy    = 1'b1;
        endcase
    end

    assign rd_cnt_next = issue ? rd_cnt_reg + LEN_W'(1) : '0;

    assign ld_pos     = (load_pos_reg >= row_len) ? '0 : load_pos_reg;
    assign ld_pos_inc = ld_pos + LEN_W'(1);

    always_comb
    begin
        load_pos_next = load_pos_reg;
        if (accept && req_type_t'(req_type) == REQ_LOAD)
        begin
            load_pos_next = (ld_pos_inc >= row_len) ? '0 : ld_pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            load_pos_reg <= '0;
            b_vld_reg    <= 1'b0;
            c_vld_reg    <= 1'b0;
            d_vld_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            load_pos_reg <= load_pos_next;
            b_vld_reg    <= issue;
            c_vld_reg    <= b_proc;
            d_vld_reg    <= c_vld_reg;
            strobe_reg   <= load_wr || d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ld_idx_reg <= ld_pos[IDX_W-1:0];
            ld_val_reg <= (ld_pos == '0 || ld_pos == row_len - LEN_W'(1)) ? '0 : sample;
        end
    end

    // ------------------------------------------------------------------
    // row memories
    // ------------------------------------------------------------------
    assign ram_wr_en    = load_wr || d_vld_reg;
    assign ram_wr_addr  = load_wr ? ld_idx_reg : d_idx_reg;
    assign cur_wr_data  = load_wr ? ld_val_reg : d_next_reg;
    assign prev_wr_data = load_wr ? ld_val_reg : d_mid_reg;

    wes_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_POINTS)
    ) u_cur_row (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (cur_wr_data),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (cur_rd_data)
    );

    wes_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_POINTS)
    ) u_prev_row (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (prev_wr_data),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (prev_rd_data)
    );

    // ------------------------------------------------------------------
    // stencil pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_idx_reg <= rd_cnt_reg;
        end
        if (b_vld_reg)
        begin
            win_l_reg  <= win_m_reg;
            win_m_reg  <= $signed(cur_rd_data);
            prev_d_reg <= $signed(prev_rd_data);
        end
    end

    assign b_proc  = b_vld_reg && (b_idx_reg != '0);
    assign b_point = b_idx_reg - LEN_W'(1);
    assign lap     = 18'(win_l_reg) - (18'(win_m_reg) <<< 1) + 18'($signed(cur_rd_data));

    always_ff @(posedge clk)
    begin
        if (b_proc)
        begin
            c_idx_reg  <= b_point[IDX_W-1:0];
            c_prod_reg <= 35'(lap) * 35'($signed({1'b0, coeff_reg}));
            c_mid_reg  <= win_m_reg;
            c_prev_reg <= prev_d_reg;
            c_edge_reg <= (b_point == '0) || (b_point == row_len - LEN_W'(1));
            c_last_reg <= (b_point == row_len - LEN_W'(1));
        end
    end

    assign c_rnd  = 36'(c_prod_reg) + 36'sd32768;
    assign c_term = c_rnd[35:16];
    assign c_sum  = 22'(c_term) + (22'(c_mid_reg) <<< 1) - 22'(c_prev_reg);

    always_comb
    begin
        if (c_edge_reg)
        begin
            c_next = '0;
        end
        else if (c_sum > 22'sd32767)
        begin
            c_next = 16'sh7FFF;
        end
        else if (c_sum < -22'sd32768)
        begin
            c_next = 16'sh8000;
        end
        else
        begin
            c_next = c_sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_vld_reg)
        begin
            d_idx_reg  <= c_idx_reg;
            d_next_reg <= c_next;
            d_mid_reg  <= c_mid_reg;
            d_last_reg <= c_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // result
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            pixel_reg <= grey_level(ld_val_reg);
            index_reg <= ld_idx_reg;
            last_reg  <= 1'b0;
        end
        else if (d_vld_reg)
        begin
            pixel_reg <= grey_level(d_next_reg);
            index_reg <= d_idx_reg;
            last_reg  <= d_last_reg;
        end
    end

    assign strobe      = strobe_reg;
    assign pixel       = pixel_reg;
    assign point_index = index_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_IDLE) && strobe)
        else $error("load did not return exactly one result");

    a_writeback_busy: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg |-> busy)
        else $error("write-back pending while idle");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && d_vld_reg) |-> (ram_wr_addr != rd_cnt_reg[IDX_W-1:0]))
        else $error("row read and write-back hit the same entry");
`endif

endmodule

### hdl/wes_ram.sv
// ----------------------------------------------------------------------------
// wes_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module wes_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sim/wave_equation_stencil_step_unit_tb.sv
// ----------------------------------------------------------------------------
// wave_equation_stencil_step_unit_tb
// Drives load and step requests into the string stencil unit, predicts every
// grey pixel with an independent fixed-point model of the string and checks
// each strobed result, field by field, against the oldest pending prediction.
// Directed rows hit sample extremes, saturation, a clamped row length and a
// load position left beyond a shortened row; random rows follow.
// ----------------------------------------------------------------------------
module wave_equation_stencil_step_unit_tb;

    import wes_pkg::*;

    typedef struct {
        logic [PIXEL_W-1:0] grey;
        logic [IDX_W-1:0]   idx;
        logic               is_last;
    } pixel_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    req_type_t                  req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       strobe;
    logic [PIXEL_W-1:0]         pixel;
    logic [IDX_W-1:0]           point_index;
    logic                       last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    cfg_index_t                 cfg_index;
    logic [15:0]                cfg_data;

    logic signed [SAMPLE_W-1:0] prev_disp [MAX_POINTS];
    logic signed [SAMPLE_W-1:0] cur_disp [MAX_POINTS];
    int unsigned                load_ptr = 0;
    logic [LEN_W-1:0]           points_reg = MAX_LEN;
    logic [COEFF_W-1:0]         coeff_reg = COEFF_RESET;

    pixel_result_t pending_pixels[$];
    int            err_count = 0;
    int            random_items = 0;
    bit            no_gaps = 1'b0;

    wave_equation_stencil_step_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .sample      (sample),
        .strobe      (strobe),
        .pixel       (pixel),
        .point_index (point_index),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic log_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int unsigned row_len();
        int unsigned n;
        n = 32'(points_reg);
        if (n < 3)
            n = 3;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        return n;
    endfunction

    function automatic logic [PIXEL_W-1:0] grey_of(input logic signed [SAMPLE_W-1:0] v);
        longint scaled;
        scaled = (longint'(v) + 16384) * 127;
        if (scaled < 0)
            return '0;
        scaled = scaled >>> 14;
        if (scaled > 255)
            return '1;
        return scaled[PIXEL_W-1:0];
    endfunction

    function automatic void predict_load(input logic signed [SAMPLE_W-1:0] value);
        int unsigned                n;
        int unsigned                pos;
        logic signed [SAMPLE_W-1:0] stored;
        n = row_len();
        pos = load_ptr;
        if (pos >= n)
            pos = 0;
        stored = (pos == 0 || pos == n - 1) ? '0 : value;
        prev_disp[pos] = stored;
        cur_disp[pos] = stored;
        pending_pixels.push_back('{grey: grey_of(stored), idx: IDX_W'(pos), is_last: 1'b0});
        load_ptr = (pos + 1 >= n) ? 0 : pos + 1;
    endfunction

    function automatic void predict_step();
        int unsigned                n;
        longint                     lap;
        longint                     term;
        longint                     total;
        logic signed [SAMPLE_W-1:0] nxt [MAX_POINTS];
        n = row_len();
        foreach (nxt[i])
            nxt[i] = '0;
        for (int i = 1; i < int'(n) - 1; i++)
        begin
            lap = longint'(cur_disp[i-1]) - 2 * longint'(cur_disp[i]) + longint'(cur_disp[i+1]);
            term = (lap * longint'(coeff_reg) + 32768) >>> 16;
            total = term + 2 * longint'(cur_disp[i]) - longint'(prev_disp[i]);
            if (total > 32767)
                total = 32767;
            else if (total < -32768)
                total = -32768;
            nxt[i] = total[SAMPLE_W-1:0];
        end
        for (int i = 0; i < int'(n); i++)
        begin
            prev_disp[i] = cur_disp[i];
            cur_disp[i] = nxt[i];
            pending_pixels.push_back('{grey: grey_of(nxt[i]), idx: IDX_W'(i),
                                       is_last: (i == int'(n) - 1)});
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1, 2:    return SAMPLE_W'($urandom);
            default: return SAMPLE_W'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_points();
        case ($urandom_range(0, 19))
            0:       return LEN_W'($urandom_range(0, 2));
            1:       return LEN_W'($urandom_range(65, 127));
            2:       return MAX_LEN;
            3, 4:    return LEN_W'($urandom_range(13, 63));
            default: return LEN_W'($urandom_range(3, 12));
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return COEFF_RESET;
            3:       return COEFF_W'($urandom_range(0, 4000));
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    // hold start high across back-to-back requests; drop it only for a gap
    task automatic send_request(input req_type_t kind, input logic signed [SAMPLE_W-1:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        sample   <= value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (kind == REQ_LOAD)
            predict_load(value);
        else
            predict_step();
        @(negedge clk);
    endtask

    task automatic wait_for_quiet();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t which, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (which == CFG_POINTS)
            points_reg = data[LEN_W-1:0];
        else
            coeff_reg = data;
        @(negedge clk);
    endtask

    task automatic configure(input logic [LEN_W-1:0] pts, input logic [COEFF_W-1:0] coeff);
        logic [15-LEN_W:0] upper;
        upper = (16-LEN_W)'($urandom);
        write_register(CFG_POINTS, {upper, pts});
        write_register(CFG_COEFF, coeff);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_request(REQ_LOAD, 16'sh7fff);
        send_request(REQ_LOAD, 16'sh4000);
        send_request(REQ_LOAD, 16'sh8000);
    endtask

    task automatic test_row_extremes();
        wait_for_quiet();
        configure(LEN_W'(5), '1);
        send_request(REQ_LOAD, 16'sh7fff);
        send_request(REQ_LOAD, 16'sh8000);
        send_request(REQ_LOAD, 16'sh7fff);
        send_request(REQ_LOAD, 16'sh8000);
        send_request(REQ_LOAD, 16'sh7fff);
        repeat (3) send_request(REQ_STEP, 16'sh0000);
    endtask

    task automatic test_short_row();
        wait_for_quiet();
        configure(LEN_W'(5), '0);
        send_request(REQ_LOAD, 16'sh1234);
        wait_for_quiet();
        configure('0, '0);
        send_request(REQ_LOAD, 16'sh5555);
        send_request(REQ_LOAD, 16'shc000);
        send_request(REQ_LOAD, 16'sh2aaa);
        repeat (2) send_request(REQ_STEP, 16'shffff);
    endtask

    task automatic test_random_rows();
        int unsigned n;
        while (random_items < 420)
        begin
            wait_for_quiet();
            configure(pick_points(), pick_coeff());
            no_gaps = ($urandom_range(0, 3) == 0);
            n = row_len();
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, n - 1))
                begin
                    send_request(REQ_LOAD, rand_sample());
                    random_items++;
                end
            end
            else
            begin
                repeat (n)
                begin
                    send_request(REQ_LOAD, rand_sample());
                    random_items++;
                end
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        repeat ($urandom_range(1, 2))
                        begin
                            send_request(REQ_LOAD, rand_sample());
                            random_items++;
                        end
                    end
                    send_request(REQ_STEP, rand_sample());
                    random_items++;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && strobe)
        begin
            if (pending_pixels.size() == 0)
                log_mismatch($sformatf("unexpected result for point %0d", point_index));
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel !== want.grey)
                    log_mismatch($sformatf("pixel %0d, predicted %0d at point %0d",
                                           pixel, want.grey, want.idx));
                if (point_index !== want.idx)
                    log_mismatch($sformatf("point_index %0d, predicted %0d",
                                           point_index, want.idx));
                if (last !== want.is_last)
                    log_mismatch($sformatf("last %0b, predicted %0b at point %0d",
                                           last, want.is_last, want.idx));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req_type  = REQ_LOAD;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POINTS;
        cfg_data  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_row_extremes();
        test_short_row();
        test_random_rows();

        wait_for_quiet();
        if (pending_pixels.size() != 0)
            log_mismatch($sformatf("%0d predicted results never arrived", pending_pixels.size()));
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
